### rtl/velocity_frame_rotation_core_assert.svh
// assertion helpers shared by the rotation core
`ifndef VELOCITY_FRAME_ROTATION_CORE_ASSERT_SVH
`define VELOCITY_FRAME_ROTATION_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define VFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vfr assertion failed");

// next-cycle implication, checked while out of reset
`define VFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vfr assertion failed");

`endif

### rtl/vfr_pkg.sv
package vfr_pkg;

	localparam int ANGLE_STEPS  = 8192;
	localparam int ANGLE_BITS   = $clog2(ANGLE_STEPS);
	localparam int ANG_W        = 13;
	localparam int VEL_W        = 16;
	localparam int EXT_W        = VEL_W + 1;
	localparam int PHASE_W      = 32;
	localparam int RES_W        = 31;
	localparam int CORDIC_W     = 32;
	localparam int DATA_SHIFT   = 12;
	localparam int ATAN_ENTRIES = 24;
	localparam int PROD_W       = 64;
	localparam int GAIN_SHIFT   = 42;
	localparam int RND_W        = PROD_W - GAIN_SHIFT;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;

	localparam logic signed [CORDIC_W-1:0] INV_GAIN  = 32'sd652032874;
	localparam logic signed [PROD_W-1:0]   GAIN_RND  = 64'sd1 <<< (GAIN_SHIFT - 1);
	localparam logic [PHASE_W-1:0]         QTR_HALF  = 32'h2000_0000;
	localparam logic signed [RES_W-1:0]    RES_BIAS  = 31'sd536870912;

	// register indexes on the write port
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_YAW_CENTER     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE_DEADBAND = 2'd1;

	typedef logic signed [EXT_W-1:0]    ext_t;
	typedef logic signed [CORDIC_W-1:0] cval_t;

	typedef struct packed {
		cval_t x;
		cval_t y;
		cval_t z;
	} rot_t;

	// values carried alongside the cordic for the bypass path
	typedef struct packed {
		ext_t             x_pre;
		ext_t             y_pre;
		logic             bypass;
		logic [VEL_W-1:0] spin;
	} pass_t;

	// atan(2^-i) in units of a turn / 2^32
	function automatic cval_t atan_turn(input int i);
		cval_t v;
		unique case (i)
			0:  v = 32'sd536870912;
			1:  v = 32'sd316933406;
			2:  v = 32'sd167458907;
			3:  v = 32'sd85004756;
			4:  v = 32'sd42667331;
			5:  v = 32'sd21354465;
			6:  v = 32'sd10679838;
			7:  v = 32'sd5340245;
			8:  v = 32'sd2670163;
			9:  v = 32'sd1335087;
			10: v = 32'sd667544;
			11: v = 32'sd333772;
			12: v = 32'sd166886;
			13: v = 32'sd83443;
			14: v = 32'sd41722;
			15: v = 32'sd20861;
			16: v = 32'sd10430;
			17: v = 32'sd5215;
			18: v = 32'sd2608;
			19: v = 32'sd1304;
			20: v = 32'sd652;
			21: v = 32'sd326;
			22: v = 32'sd163;
			23: v = 32'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [VEL_W-1:0] sat_vel(input logic signed [RND_W-1:0] v);
		logic [VEL_W-1:0] r;
		if (v > RND_W'(32767))
			r = 16'h7fff;
		else if (v < -RND_W'(32768))
			r = 16'h8000;
		else
			r = v[VEL_W-1:0];
		return r;
	endfunction

endpackage

### rtl/velocity_frame_rotation_core.sv
// channel   | dir | handshake         | payload
// s_axis    | in  | s_tvalid/s_tready | yaw_angle, vel_forward, vel_side, spin_rate
// m_axis    | out | m_tvalid/m_tready | out_forward, out_side, out_spin
// cfg       | in  | cfg_we            | cfg_index selects yaw_center / angle_deadband
//
// one transaction per cycle in and out unless a stall on m_tready holds the pipeline; the pipeline is
// two front stages, one per cordic stage, multiply and round/saturate
// arst_n clears the valid bits and the two registers; payload is not reset
// a stall on m_tready freezes the whole pipeline together and drops s_tready
`include "velocity_frame_rotation_core_assert.svh"

module velocity_frame_rotation_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// yaw_angle[12:0], vel_forward[28:13], vel_side[44:29], spin_rate[60:45]
	input  logic [vfr_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_forward[15:0], out_side[31:16], out_spin[47:32]
	output logic [vfr_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [vfr_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [vfr_pkg::ANG_W-1:0]         cfg_data
);
	import vfr_pkg::*;

	localparam int NUM_ST     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int PIPE_DEPTH = NUM_ST + 4;

	logic [ANG_W-1:0]      yaw_center_q;
	logic [ANG_W-1:0]      angle_deadband_q;
	logic [PIPE_DEPTH-1:0] valid_q;
	logic                  pipe_en;

	rot_t  rot_c  [NUM_ST+1];
	pass_t pass_c [NUM_ST+1];

	logic [VEL_W-1:0] out_forward;
	logic [VEL_W-1:0] out_side;
	logic [VEL_W-1:0] out_spin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_center_q     <= '0;
			angle_deadband_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_YAW_CENTER:     yaw_center_q     <= cfg_data;
				REG_ANGLE_DEADBAND: angle_deadband_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pipe_en  = !valid_q[PIPE_DEPTH-1] || m_tready;
	assign s_tready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (pipe_en)
			valid_q <= {valid_q[PIPE_DEPTH-2:0], s_tvalid};
	end

	vfr_front u_front (
		.clk            (clk),
		.en             (pipe_en),
		.yaw_angle      (s_tdata[12:0]),
		.vel_forward    (s_tdata[28:13]),
		.vel_side       (s_tdata[44:29]),
		.spin_rate      (s_tdata[60:45]),
		.yaw_center     (yaw_center_q),
		.angle_deadband (angle_deadband_q),
		.rot            (rot_c[0]),
		.pass           (pass_c[0])
	);

	for (genvar i = 0; i < NUM_ST; i++) begin : g_cordic
		vfr_cordic_stage #(
			.SHIFT (i)
		) u_stage (
			.clk    (clk),
			.en     (pipe_en),
			.rot_i  (rot_c[i]),
			.pass_i (pass_c[i]),
			.rot_o  (rot_c[i+1]),
			.pass_o (pass_c[i+1])
		);
	end

	vfr_gain u_gain (
		.clk         (clk),
		.en          (pipe_en),
		.rot_i       (rot_c[NUM_ST]),
		.pass_i      (pass_c[NUM_ST]),
		.out_forward (out_forward),
		.out_side    (out_side),
		.out_spin    (out_spin)
	);

	assign m_tvalid = valid_q[PIPE_DEPTH-1];
	assign m_tdata  = {out_spin, out_side, out_forward};

	`VFR_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, valid_q[0])
	`VFR_ASSERT_NEXT(a_bubble_enters, clk, arst_n, s_tready && !s_tvalid, !valid_q[0])
	`VFR_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !pipe_en, $stable(valid_q))

endmodule

### rtl/vfr_front.sv
module vfr_front (
	input  logic                        clk,
	input  logic                        en,
	input  logic [vfr_pkg::ANG_W-1:0]   yaw_angle,
	input  logic [vfr_pkg::VEL_W-1:0]   vel_forward,
	input  logic [vfr_pkg::VEL_W-1:0]   vel_side,
	input  logic [vfr_pkg::VEL_W-1:0]   spin_rate,
	input  logic [vfr_pkg::ANG_W-1:0]   yaw_center,
	input  logic [vfr_pkg::ANG_W-1:0]   angle_deadband,
	output vfr_pkg::rot_t               rot,
	output vfr_pkg::pass_t              pass
);
	import vfr_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic signed [ANG_W:0]   diff;
	logic [ANG_W:0]          mag;
	logic signed [ANG_W:0]   diff_eff;
	logic signed [PHASE_W-1:0] diff_ext;

	logic [ANGLE_BITS-1:0]   r_s1;
	logic signed [VEL_W-1:0] vf_s1;
	logic signed [VEL_W-1:0] vs_s1;
	logic [VEL_W-1:0]        spin_s1;

	logic [PHASE_W-1:0]      theta;
	logic [PHASE_W-1:0]      tt;
	logic [1:0]              quad;
	logic signed [RES_W-1:0] res;
	ext_t                    vf_e;
	ext_t                    vs_e;
	ext_t                    xq;
	ext_t                    yq;

	rot_t                    rot_s2;
	pass_t                   pass_s2;

	// signed offset, forced to zero inside the deadband
	always_comb begin
		diff     = $signed({1'b0, yaw_angle}) - $signed({1'b0, yaw_center});
		mag      = diff[ANG_W] ? (ANG_W+1)'(-diff) : diff;
		diff_eff = (mag < {1'b0, angle_deadband}) ? '0 : diff;
		diff_ext = PHASE_W'(diff_eff);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= diff_ext[ANGLE_BITS-1:0];
			vf_s1   <= vel_forward;
			vs_s1   <= vel_side;
			spin_s1 <= spin_rate;
		end
	end

	// phase to quadrant plus residual, then exact quarter-turn rotation
	always_comb begin
		theta = PHASE_W'(r_s1) << (PHASE_W - ANGLE_BITS);
		tt    = (PHASE_W'(0) - theta) + QTR_HALF;
		quad  = tt[PHASE_W-1:PHASE_W-2];
		res   = $signed({1'b0, tt[PHASE_W-3:0]}) - RES_BIAS;
		vf_e  = EXT_W'(vf_s1);
		vs_e  = EXT_W'(vs_s1);
		unique case (quad)
			QUAD_0: begin xq = vf_e;  yq = vs_e;  end
			QUAD_1: begin xq = -vs_e; yq = vf_e;  end
			QUAD_2: begin xq = -vf_e; yq = -vs_e; end
			QUAD_3: begin xq = vs_e;  yq = -vf_e; end
			default: begin xq = vf_e; yq = vs_e; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s2.x       <= CORDIC_W'(xq) <<< DATA_SHIFT;
			rot_s2.y       <= CORDIC_W'(yq) <<< DATA_SHIFT;
			rot_s2.z       <= CORDIC_W'(res);
			pass_s2.x_pre  <= xq;
			pass_s2.y_pre  <= yq;
			pass_s2.bypass <= (res == '0);
			pass_s2.spin   <= spin_s1;
		end
	end

	assign rot  = rot_s2;
	assign pass = pass_s2;

endmodule

### rtl/vfr_cordic_stage.sv
module vfr_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  logic           clk,
	input  logic           en,
	input  vfr_pkg::rot_t  rot_i,
	input  vfr_pkg::pass_t pass_i,
	output vfr_pkg::rot_t  rot_o,
	output vfr_pkg::pass_t pass_o
);
	import vfr_pkg::*;

	localparam cval_t ATAN = atan_turn(SHIFT);

	cval_t dx;
	cval_t dy;
	rot_t  nxt;
	rot_t  rot_s1;
	pass_t pass_s1;

	// zero residual counts as positive
	always_comb begin
		dx = rot_i.y >>> SHIFT;
		dy = rot_i.x >>> SHIFT;
		if (!rot_i.z[CORDIC_W-1]) begin
			nxt.x = rot_i.x - dx;
			nxt.y = rot_i.y + dy;
			nxt.z = rot_i.z - ATAN;
		end else begin
			nxt.x = rot_i.x + dx;
			nxt.y = rot_i.y - dy;
			nxt.z = rot_i.z + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1  <= nxt;
			pass_s1 <= pass_i;
		end
	end

	assign rot_o  = rot_s1;
	assign pass_o = pass_s1;

endmodule

### rtl/vfr_gain.sv
module vfr_gain (
	input  logic                      clk,
	input  logic                      en,
	input  vfr_pkg::rot_t             rot_i,
	input  vfr_pkg::pass_t            pass_i,
	output logic [vfr_pkg::VEL_W-1:0] out_forward,
	output logic [vfr_pkg::VEL_W-1:0] out_side,
	output logic [vfr_pkg::VEL_W-1:0] out_spin
);
	import vfr_pkg::*;

	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [PROD_W-1:0] px_s1;
	logic signed [PROD_W-1:0] py_s1;
	pass_t                    pass_s1;
	logic signed [PROD_W-1:0] sum_x;
	logic signed [PROD_W-1:0] sum_y;
	logic signed [RND_W-1:0]  rnd_x;
	logic signed [RND_W-1:0]  rnd_y;
	logic [VEL_W-1:0]         fwd_nxt;
	logic [VEL_W-1:0]         side_nxt;
	logic [VEL_W-1:0]         fwd_s2;
	logic [VEL_W-1:0]         side_s2;
	logic [VEL_W-1:0]         spin_s2;

	assign prod_x = PROD_W'(rot_i.x) * PROD_W'(INV_GAIN);
	assign prod_y = PROD_W'(rot_i.y) * PROD_W'(INV_GAIN);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= prod_x;
			py_s1   <= prod_y;
			pass_s1 <= pass_i;
		end
	end

	// round half up and drop the gain and data scaling, or take the bypass values, then saturate
	always_comb begin
		sum_x = px_s1 + GAIN_RND;
		sum_y = py_s1 + GAIN_RND;
		rnd_x = sum_x[PROD_W-1:GAIN_SHIFT];
		rnd_y = sum_y[PROD_W-1:GAIN_SHIFT];
		if (pass_s1.bypass) begin
			fwd_nxt  = sat_vel(RND_W'(pass_s1.x_pre));
			side_nxt = sat_vel(RND_W'(pass_s1.y_pre));
		end else begin
			fwd_nxt  = sat_vel(rnd_x);
			side_nxt = sat_vel(rnd_y);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s2  <= fwd_nxt;
			side_s2 <= side_nxt;
			spin_s2 <= pass_s1.spin;
		end
	end

	assign out_forward = fwd_s2;
	assign out_side    = side_s2;
	assign out_spin    = spin_s2;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import vfr_pkg::*;

	localparam int STAGES      = 16;
	localparam int LATENCY     = (STAGES < 24 ? STAGES : 24) + 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TURN_STEPS  = 8192;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam longint GAIN_COMP  = 652032874;
	localparam longint ROUND_HALF = 64'sd1 <<< 41;

	// atan(2^-i) as a fraction of a turn scaled by 2^32, entry 0 in the low word
	localparam logic [23:0][31:0] ARC_STEP = {
		32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608,
		32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443, 32'd166886,
		32'd333772, 32'd667544, 32'd1335087, 32'd2670163, 32'd5340245, 32'd10679838,
		32'd21354465, 32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406,
		32'd536870912
	};

	typedef struct packed {
		logic [15:0]        spin;
		logic signed [15:0] side;
		logic signed [15:0] fwd;
		logic [12:0]        yaw;
	} motion_cmd_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]    cfg_index = '0;
	logic [ANG_W-1:0]        cfg_data = '0;

	motion_cmd_t             cmd_queue[$];
	logic [OUT_DATA_W-1:0]   rotated_q[$];
	motion_cmd_t             on_offer;
	logic [12:0]             center_q = '0;
	logic [12:0]             deadband_q = '0;
	int                      send_gap = 0;
	int                      recv_gap = 0;
	bit                      send_idle_on = 1'b0;
	bit                      recv_idle_on = 1'b0;
	bit                      hold_go = 1'b0;
	logic                    long_hold = 1'b0;
	int                      mismatches = 0;
	int                      cycles = 0;
	string                   field_name[3] = '{"out_forward", "out_side", "out_spin"};

	velocity_frame_rotation_core #(
		.CORDIC_STAGES(STAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		// yaw_angle[12:0], vel_forward[28:13], vel_side[44:29], spin_rate[60:45]
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// out_forward[15:0], out_side[31:16], out_spin[47:32]
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] clamp_q88(input longint v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic logic [OUT_DATA_W-1:0] rotate_velocity(input motion_cmd_t c);
		longint diff, mag, r, resid, x, y, dx, dy, xo, yo;
		longint unsigned theta, phi, tt;
		int quad;
		diff = longint'(c.yaw) - longint'(center_q);
		mag = diff < 0 ? -diff : diff;
		if (mag < longint'(deadband_q))
			diff = 0;
		r = diff % TURN_STEPS;
		if (r < 0)
			r += TURN_STEPS;
		theta = ((unsigned'(r) << 32) + (TURN_STEPS >> 1)) / TURN_STEPS;
		phi = (64'h1_0000_0000 - theta) & 64'hffff_ffff;
		tt = (phi + 64'h2000_0000) & 64'hffff_ffff;
		quad = int'((tt >> 30) & 3);
		resid = longint'(tt & 64'h3fff_ffff) - 64'sd536870912;
		case (quad)
			1: begin
				x = -longint'(c.side);
				y = longint'(c.fwd);
			end
			2: begin
				x = -longint'(c.fwd);
				y = -longint'(c.side);
			end
			3: begin
				x = longint'(c.side);
				y = -longint'(c.fwd);
			end
			default: begin
				x = longint'(c.fwd);
				y = longint'(c.side);
			end
		endcase
		if (resid == 0) begin
			// exact quarter turn, no cordic
			xo = x;
			yo = y;
		end else begin
			x = x <<< 12;
			y = y <<< 12;
			for (int i = 0; i < STAGES && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (resid >= 0) begin
					x = x - dx;
					y = y + dy;
					resid = resid - longint'(ARC_STEP[i]);
				end else begin
					x = x + dx;
					y = y - dy;
					resid = resid + longint'(ARC_STEP[i]);
				end
			end
			xo = (x * GAIN_COMP + ROUND_HALF) >>> 42;
			yo = (y * GAIN_COMP + ROUND_HALF) >>> 42;
		end
		return {c.spin, clamp_q88(yo), clamp_q88(xo)};
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_vel();
		logic [15:0] corner[6] = '{16'h8000, 16'h8001, 16'hffff, 16'h0000, 16'h0001, 16'h7fff};
		if ($urandom_range(0, 4) == 0)
			return corner[$urandom_range(0, 5)];
		return 16'($urandom);
	endfunction

	function automatic motion_cmd_t random_cmd();
		motion_cmd_t c;
		case ($urandom_range(0, 9))
			0: c.yaw = 13'(center_q + 2048 * $urandom_range(0, 3));
			1: c.yaw = 13'(center_q + deadband_q + $urandom_range(0, 2) - 1);
			2: c.yaw = 13'(center_q - deadband_q + $urandom_range(0, 2) - 1);
			default: c.yaw = 13'($urandom_range(0, 8191));
		endcase
		c.fwd = pick_vel();
		c.side = pick_vel();
		c.spin = pick_vel();
		return c;
	endfunction

	task automatic queue_cmd(input int yaw, input int fwd, input int side, input int spin);
		motion_cmd_t c;
		c.yaw = 13'(yaw);
		c.fwd = 16'(fwd);
		c.side = 16'(side);
		c.spin = 16'(spin);
		cmd_queue.push_back(c);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ANG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_YAW_CENTER)
			center_q = val;
		else if (idx == REG_ANGLE_DEADBAND)
			deadband_q = val;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || rotated_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input logic [12:0] center, input logic [12:0] deadband,
			input int count, input bit send_idle, input bit recv_idle);
		wait_drained();
		write_reg(REG_YAW_CENTER, center);
		write_reg(REG_ANGLE_DEADBAND, deadband);
		send_idle_on = send_idle;
		recv_idle_on = recv_idle;
		repeat (count)
			cmd_queue.push_back(random_cmd());
	endtask

	// sender: holds the transaction until accepted, then maybe idles
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				rotated_q.push_back(rotate_velocity(on_offer));
				send_gap = send_idle_on ? pick_gap() : 0;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					on_offer = cmd_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, on_offer};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result against the oldest prediction
	always @(posedge clk) begin
		logic [OUT_DATA_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = rotated_q.pop_front();
					for (int f = 0; f < 3; f++)
						if (m_tdata[16*f +: 16] !== want[16*f +: 16]) begin
							$display("%0t: %s expected %0d got %0d", $time, field_name[f],
								$signed(want[16*f +: 16]), $signed(m_tdata[16*f +: 16]));
							mismatches++;
						end
				end
			end
			if (long_hold) begin
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap = recv_idle_on ? pick_gap() : 0;
			end
		end
	end

	// one long back-pressure stretch so the pipeline fills and s_tready drops
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (120) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("velocity_frame_rotation_core regression: fail");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// quarter turns, extremes and the -32768 negation
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		write_reg(REG_YAW_CENTER, 13'd0);
		write_reg(REG_ANGLE_DEADBAND, 13'd0);
		queue_cmd(0, 32767, -32768, 0);
		queue_cmd(2048, -32768, 32767, 32767);
		queue_cmd(4096, -32768, -32768, -32768);
		queue_cmd(6144, -32768, 32767, 1);
		queue_cmd(6144, 32767, -32768, -1);
		queue_cmd(1024, 32767, 32767, 256);
		queue_cmd(1024, -32768, -32768, -256);
		queue_cmd(7168, 32767, -32768, 12345);
		queue_cmd(8191, 256, -256, 0);
		queue_cmd(1, -1, 1, 0);
		queue_cmd(5000, 0, 0, 0);
		queue_cmd(3000, 12800, -6400, 100);
		wait_drained();

		// wide deadband: only the largest offset escapes it; spare indexes are ignored
		write_reg(REG_YAW_CENTER, 13'd8191);
		write_reg(REG_ANGLE_DEADBAND, 13'd8191);
		write_reg(REG_SPARE_A, 13'd4321);
		write_reg(REG_SPARE_B, 13'd1234);
		queue_cmd(0, 32767, 1000, 7);
		queue_cmd(1, 32767, 1000, 7);
		queue_cmd(100, -32768, 32767, 7);
		queue_cmd(8191, 1000, -1000, 7);
		wait_drained();

		write_reg(REG_YAW_CENTER, 13'd100);
		write_reg(REG_ANGLE_DEADBAND, 13'd5);
		queue_cmd(95, 5000, 5000, 0);
		queue_cmd(96, 5000, 5000, 0);
		queue_cmd(105, 5000, 5000, 0);
		queue_cmd(104, 5000, 5000, 0);
		queue_cmd(0, 5000, 5000, 0);

		run_phase(13'($urandom), 13'd0, 160, 1'b1, 1'b1);
		hold_go = 1'b1;
		run_phase(13'($urandom), 13'($urandom_range(0, 400)), 160, 1'b0, 1'b0);
		run_phase(13'd8191, 13'd0, 130, 1'b1, 1'b1);
		run_phase(13'd0, 13'd8191, 80, 1'b1, 1'b1);
		run_phase(13'($urandom), 13'($urandom), 130, 1'b1, 1'b1);
		run_phase(13'($urandom), 13'($urandom_range(0, 64)), 140, 1'b1, 1'b0);

		wait_drained();
		repeat (LATENCY + 8) @(negedge clk);
		if (mismatches == 0)
			$display("velocity_frame_rotation_core regression: pass");
		else
			$display("velocity_frame_rotation_core regression: fail");
		$finish;
	end

endmodule
